// ----- hdl/assert_macros.svh -----
// Assertion macros for the oldest-waiting task scheduler.
// No dependencies; included by the top level, the only file with concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define OWTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("owts: check failed");
// Antecedent at one edge implies consequent at the next edge.
`define OWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owts: next-cycle check failed");
`else
`define OWTS_ASSERT(lbl, clk, rst_n, prop)
`define OWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/owts_pkg.sv -----
// Shared types and codes of the oldest-waiting task scheduler:
// payload structs, event/state/status codes, controller command and status.
// No dependencies.
`default_nettype none

package owts_pkg;

	localparam int HART_W  = 3;
	localparam int STATE_W = 3;

	// event kinds
	localparam logic [2:0] KIND_INIT  = 3'd0;
	localparam logic [2:0] KIND_YIELD = 3'd1;
	localparam logic [2:0] KIND_BLOCK = 3'd2;
	localparam logic [2:0] KIND_EXIT  = 3'd3;
	localparam logic [2:0] KIND_RUN   = 3'd4;
	localparam logic [2:0] KIND_WAKE  = 3'd5;

	// slot states
	localparam logic [STATE_W-1:0] ST_FREE     = 3'd0;
	localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd1;
	localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd2;
	localparam logic [STATE_W-1:0] ST_BLOCKED  = 3'd3;
	localparam logic [STATE_W-1:0] ST_ZOMBIE   = 3'd4;

	// result status
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOFREE = 2'd1;
	localparam logic [1:0] STATUS_NORUN  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  caller_slot;
		logic [3:0]  target_slot;
		logic [2:0]  hart_id;
		logic [31:0] now;
	} ev_t;

	typedef struct packed {
		logic [3:0] next_slot;
		logic       switched;
		logic [2:0] next_hart;
		logic [1:0] status;
	} res_t;

	typedef enum logic [1:0] {
		RD_CALLER = 2'd0,
		RD_TARGET = 2'd1,
		RD_SCAN   = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE       = 3'd0,
		WR_INIT       = 3'd1,
		WR_MARK       = 3'd2,
		WR_WAKE       = 3'd3,
		WR_PICK       = 3'd4,
		WR_RUN_CALLER = 3'd5,
		WR_RUN_NEW    = 3'd6
	} wr_op_t;

	typedef enum logic [2:0] {
		RES_BAD    = 3'd0,
		RES_INIT   = 3'd1,
		RES_PLAIN  = 3'd2,
		RES_PICK   = 3'd3,
		RES_NORUN  = 3'd4,
		RES_NOFREE = 3'd5
	} res_sel_t;

	typedef struct packed {
		logic     load;
		rd_sel_t  rd_sel;
		logic     scan_start;
		logic     scan_step;
		logic     cap_caller;
		wr_op_t   wr_op;
		logic     res_en;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       caller_ok;
		logic       found;
		logic       scan_last;
		logic       scan_busy;
	} sts_t;

endpackage

`default_nettype wire

// ----- hdl/owts_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is supplied by the user (owts_pkg::ev_t or owts_pkg::res_t).
`default_nettype none

interface owts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/oldest_waiting_task_scheduler.sv -----
// Oldest-waiting-first task scheduler, top level.
// Depends on owts_pkg, owts_stream_if, owts_ctrl, owts_dp and assert_macros.svh.
//
// Usage:
//   ev  (sink)   : one scheduling event per transfer: kind, caller_slot,
//                  target_slot, hart_id, now.
//   res (source) : exactly one result per event: next_slot, switched,
//                  next_hart, status.
// One event is in flight at a time; ev.ready is high only while idle.
// Each event is registered, its caller row read, then dispatched:
//   init, unknown kind, out-of-range caller: result set at dispatch;
//   wake: target row read, then written; yield / block / exit / run:
//   scan of all SLOTS rows, drain, commit; run adds the S_RUN2 write
//   when a free slot is found. The scan reads one table row per cycle
//   through the single memory read port.
// Reset clears all slot valid bits at once, so every slot reads free with
// zero time and hart 0; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and
// the next event is still taken; the scheduler holds its finished result
// internally until the output register frees up.
`default_nettype none
`include "assert_macros.svh"

module oldest_waiting_task_scheduler #(
	parameter int SLOTS     = 16,
	parameter int HARTS     = 8,
	parameter int TIME_BITS = 32
) (
	input wire logic      clk,
	input wire logic      arst_n,
	owts_stream_if.sink   ev,
	owts_stream_if.source res
);

	owts_pkg::cmd_t cmd;
	owts_pkg::sts_t sts;
	owts_pkg::res_t res_payload;

	// sequencer: handshakes and command generation
	owts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ev.valid),
		.in_ready  (ev.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot table, scan stage and result registers
	owts_dp #(
		.SLOTS     (SLOTS),
		.HARTS     (HARTS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_data  (ev.data),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (res_payload)
	);

	assign res.data = res_payload;

	// accepting an event closes the input until its result is queued
	`OWTS_ASSERT_NEXT(a_single_event, clk, arst_n, ev.valid && ev.ready, !ev.ready)
	// scan-stage zombie frees and sequencer writes never share the write port
	`OWTS_ASSERT(a_wr_port_free, clk, arst_n, !(sts.scan_busy && cmd.wr_op != owts_pkg::WR_NONE))
	// output register is only reloaded when empty or being drained
	`OWTS_ASSERT(a_out_load_free, clk, arst_n, !cmd.out_load || !res.valid || res.ready)
	// a loaded result is presented on the next cycle
	`OWTS_ASSERT_NEXT(a_out_shown, clk, arst_n, cmd.out_load, res.valid)

endmodule

`default_nettype wire

// ----- hdl/owts_ctrl.sv -----
// Sequencing state machine of the scheduler: caller read, dispatch,
// as needed wake or scan and commit, then output. Uses owts_pkg.
`default_nettype none

module owts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  owts_pkg::sts_t     sts,
	output owts_pkg::cmd_t     cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CRD    = 10'b0000000010,
		S_DISP   = 10'b0000000100,
		S_TRD    = 10'b0000001000,
		S_WAKE   = 10'b0000010000,
		S_SCAN   = 10'b0000100000,
		S_DRAIN  = 10'b0001000000,
		S_COMMIT = 10'b0010000000,
		S_RUN2   = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.rd_sel     = owts_pkg::RD_CALLER;
		cmd.wr_op      = owts_pkg::WR_NONE;
		cmd.res_sel    = owts_pkg::RES_PLAIN;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CRD;
				end
			end
			S_CRD: begin
				cmd.rd_sel = owts_pkg::RD_CALLER;
				state_d    = S_DISP;
			end
			S_DISP: begin
				cmd.cap_caller = 1'b1;
				if (!sts.caller_ok) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = owts_pkg::RES_BAD;
					state_d     = S_OUT;
				end else begin
					case (sts.kind)
						owts_pkg::KIND_INIT: begin
							cmd.wr_op   = owts_pkg::WR_INIT;
							cmd.res_en  = 1'b1;
							cmd.res_sel = owts_pkg::RES_INIT;
							state_d     = S_OUT;
						end
						owts_pkg::KIND_YIELD, owts_pkg::KIND_BLOCK,
						owts_pkg::KIND_EXIT: begin
							cmd.wr_op      = owts_pkg::WR_MARK;
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
						owts_pkg::KIND_RUN: begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
						owts_pkg::KIND_WAKE: begin
							state_d = S_TRD;
						end
						default: begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = owts_pkg::RES_PLAIN;
							state_d     = S_OUT;
						end
					endcase
				end
			end
			S_TRD: begin
				cmd.rd_sel = owts_pkg::RD_TARGET;
				state_d    = S_WAKE;
			end
			S_WAKE: begin
				cmd.wr_op   = owts_pkg::WR_WAKE;
				cmd.res_en  = 1'b1;
				cmd.res_sel = owts_pkg::RES_PLAIN;
				state_d     = S_OUT;
			end
			S_SCAN: begin
				cmd.rd_sel    = owts_pkg::RD_SCAN;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.kind == owts_pkg::KIND_RUN) begin
					if (sts.found) begin
						cmd.wr_op = owts_pkg::WR_RUN_CALLER;
						state_d   = S_RUN2;
					end else begin
						cmd.res_en  = 1'b1;
						cmd.res_sel = owts_pkg::RES_NOFREE;
						state_d     = S_OUT;
					end
				end else begin
					cmd.res_en = 1'b1;
					if (sts.found) begin
						cmd.wr_op   = owts_pkg::WR_PICK;
						cmd.res_sel = owts_pkg::RES_PICK;
					end else begin
						cmd.res_sel = owts_pkg::RES_NORUN;
					end
					state_d = S_OUT;
				end
			end
			S_RUN2: begin
				cmd.wr_op   = owts_pkg::WR_RUN_NEW;
				cmd.res_en  = 1'b1;
				cmd.res_sel = owts_pkg::RES_PICK;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/owts_dp.sv -----
// Scheduler datapath: slot table memory with per-row valid bits, scan
// pipeline stage, pick/compare logic, result and output registers. Uses owts_pkg.
`default_nettype none

module owts_dp #(
	parameter int SLOTS     = 16,
	parameter int HARTS     = 8,
	parameter int TIME_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  owts_pkg::ev_t   ev_data,
	input  owts_pkg::cmd_t  cmd,
	output owts_pkg::sts_t  sts,
	output owts_pkg::res_t  res_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int HW = owts_pkg::HART_W;
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	typedef struct packed {
		logic [owts_pkg::STATE_W-1:0] state;
		logic [HW-1:0]                hart;
		logic [TIME_BITS-1:0]         wtime;
	} row_t;

	// reduce hart_id into 0..HARTS-1 by repeated subtraction
	function automatic logic [HW-1:0] hart_mod(input logic [HW-1:0] h);
		logic [6:0] v;
		v = 7'(h);
		for (int i = 0; i < 8; i++) begin
			if (v >= 7'(HARTS)) v = v - 7'(HARTS);
		end
		return HW'(v);
	endfunction

	row_t             mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	row_t             rd_data_q;
	logic             rd_vld_q;
	row_t             row;

	logic [2:0]           kind_q;
	logic [3:0]           caller_raw_q;
	logic [SW-1:0]        caller_q;
	logic                 caller_ok_q;
	logic [SW-1:0]        target_q;
	logic                 target_ok_q;
	logic [HW-1:0]        hart_q;
	logic [TIME_BITS-1:0] now_q;
	logic [HW-1:0]        caller_hart_q;
	logic [HW-1:0]        caller_hart_w;

	logic [SW-1:0]        scan_idx_q;
	logic                 scan_vld_s1;
	logic [SW-1:0]        scan_idx_s1;
	logic                 found_q;
	logic [SW-1:0]        pick_q;
	logic [TIME_BITS-1:0] pick_time_q;
	logic                 zombie_free;
	logic                 take;

	logic                 wr_en;
	logic [SW-1:0]        wr_addr;
	row_t                 wr_row;
	logic [SW-1:0]        rd_addr;
	logic [owts_pkg::STATE_W-1:0] mark;

	owts_pkg::res_t res_q, res_d, out_q;

	// never-written rows read as free with zero time and hart
	assign row           = rd_vld_q ? rd_data_q : '0;
	assign caller_hart_w = cmd.cap_caller ? row.hart : caller_hart_q;

	always_comb begin
		case (cmd.rd_sel)
			owts_pkg::RD_TARGET: rd_addr = target_q;
			owts_pkg::RD_SCAN:   rd_addr = scan_idx_q;
			default:             rd_addr = caller_q;
		endcase
	end

	always_comb begin
		case (kind_q)
			owts_pkg::KIND_YIELD: mark = owts_pkg::ST_RUNNABLE;
			owts_pkg::KIND_BLOCK: mark = owts_pkg::ST_BLOCKED;
			default:              mark = owts_pkg::ST_ZOMBIE;
		endcase
	end

	// scan stage decisions
	assign zombie_free = scan_vld_s1 && (kind_q != owts_pkg::KIND_RUN) &&
		(row.state == owts_pkg::ST_ZOMBIE) && (scan_idx_s1 != caller_q);

	always_comb begin
		take = 1'b0;
		if (scan_vld_s1) begin
			if (kind_q == owts_pkg::KIND_RUN) begin
				take = !found_q && (row.state == owts_pkg::ST_FREE) &&
					(scan_idx_s1 != caller_q);
			end else begin
				take = !zombie_free && (row.state == owts_pkg::ST_RUNNABLE) &&
					(!found_q || (row.wtime < pick_time_q));
			end
		end
	end

	// single write port: scan stage frees zombies, controller ops otherwise
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = caller_q;
		wr_row  = row;
		if (zombie_free) begin
			wr_en        = 1'b1;
			wr_addr      = scan_idx_s1;
			wr_row.state = owts_pkg::ST_FREE;
		end else begin
			case (cmd.wr_op)
				owts_pkg::WR_INIT: begin
					wr_en        = 1'b1;
					wr_row.state = owts_pkg::ST_RUNNING;
					wr_row.hart  = hart_q;
				end
				owts_pkg::WR_MARK: begin
					wr_en        = 1'b1;
					wr_row.state = mark;
					if (kind_q == owts_pkg::KIND_YIELD) wr_row.wtime = now_q;
				end
				owts_pkg::WR_WAKE: begin
					wr_en        = target_ok_q && (row.state == owts_pkg::ST_BLOCKED);
					wr_addr      = target_q;
					wr_row.state = owts_pkg::ST_RUNNABLE;
					wr_row.wtime = now_q;
				end
				owts_pkg::WR_PICK: begin
					wr_en   = 1'b1;
					wr_addr = pick_q;
					wr_row  = '{state: owts_pkg::ST_RUNNING, hart: caller_hart_q,
						wtime: pick_time_q};
				end
				owts_pkg::WR_RUN_CALLER: begin
					wr_en  = 1'b1;
					wr_row = '{state: owts_pkg::ST_RUNNABLE, hart: caller_hart_q,
						wtime: now_q};
				end
				owts_pkg::WR_RUN_NEW: begin
					wr_en   = 1'b1;
					wr_addr = pick_q;
					wr_row  = '{state: owts_pkg::ST_RUNNING, hart: caller_hart_q,
						wtime: now_q};
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res_d = '{next_slot: 4'(caller_q), switched: 1'b0, next_hart: caller_hart_w,
			status: owts_pkg::STATUS_OK};
		case (cmd.res_sel)
			owts_pkg::RES_BAD: begin
				res_d.next_slot = caller_raw_q;
				res_d.next_hart = '0;
			end
			owts_pkg::RES_INIT: begin
				res_d.next_hart = hart_q;
			end
			owts_pkg::RES_PICK: begin
				res_d.next_slot = 4'(pick_q);
				res_d.switched  = (pick_q != caller_q);
			end
			owts_pkg::RES_NORUN: begin
				res_d.status = owts_pkg::STATUS_NORUN;
			end
			owts_pkg::RES_NOFREE: begin
				res_d.status = owts_pkg::STATUS_NOFREE;
			end
			default: begin
				res_d.status = owts_pkg::STATUS_OK;
			end
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_vld_q    <= 1'b0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			rd_vld_q    <= valid_q[rd_addr];
			scan_vld_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q       <= ev_data.kind;
			caller_raw_q <= ev_data.caller_slot;
			caller_q     <= SW'(ev_data.caller_slot);
			caller_ok_q  <= (32'(ev_data.caller_slot) < 32'(SLOTS));
			target_q     <= SW'(ev_data.target_slot);
			target_ok_q  <= (32'(ev_data.target_slot) < 32'(SLOTS));
			hart_q       <= hart_mod(ev_data.hart_id);
			now_q        <= TIME_BITS'(ev_data.now);
		end
		if (cmd.cap_caller) caller_hart_q <= row.hart;
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + SW'(1);
		end
		scan_idx_s1 <= scan_idx_q;
		if (take) begin
			pick_q      <= scan_idx_s1;
			pick_time_q <= row.wtime;
		end
		if (cmd.res_en) res_q <= res_d;
		if (cmd.out_load) out_q <= res_q;
	end

	assign sts.kind      = kind_q;
	assign sts.caller_ok = caller_ok_q;
	assign sts.found     = found_q;
	assign sts.scan_last = (scan_idx_q == LAST);
	assign sts.scan_busy = scan_vld_s1;
	assign res_data      = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_oldest_waiting_task_scheduler.sv -----
// Self-checking testbench for the oldest-waiting task scheduler.
// Depends on owts_pkg, owts_stream_if and the oldest_waiting_task_scheduler RTL.
// Events go in over a valid/ready channel and are scored against an internal slot-table model.
`timescale 1ns / 1ps

module tb_oldest_waiting_task_scheduler;

	localparam int NUM_SLOTS   = 16;
	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYC   = 40;    // longer than the slowest event takes to finish
	localparam int RAND_EVENTS = 500;
	localparam int TAIL_EVENTS = 100;   // final stretch with no idling on either side
	localparam int HOLD_CYC    = 300;   // long receiver hold-off

	// the kind field is 3 bits wide; 6 and 7 are undefined and must act as no-ops
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	logic clk;
	logic arst_n;

	owts_stream_if #(.payload_t(owts_pkg::ev_t))  ev_if ();
	owts_stream_if #(.payload_t(owts_pkg::res_t)) res_if ();

	oldest_waiting_task_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev_if),
		.res    (res_if)
	);

	// ------------------------------------------------------------------
	// Slot-table model: state, wait stamp and hart of every slot.
	// Updated once per accepted event, in transfer order.
	// ------------------------------------------------------------------
	logic [owts_pkg::STATE_W-1:0] slot_st   [NUM_SLOTS];
	logic [31:0]                  slot_wait [NUM_SLOTS];
	logic [owts_pkg::HART_W-1:0]  slot_hrt  [NUM_SLOTS];

	owts_pkg::res_t due_results [$];   // predicted results, oldest first

	int  mismatches;
	int  cycle_count;
	int  rx_hold_req;        // receiver hold-off request, in cycles
	bit  tx_idle_en;
	bit  rx_idle_en;
	logic [31:0] clock_now;  // running time base for well-formed stamps

	function automatic owts_pkg::res_t make_result(int slot, int caller,
			logic [owts_pkg::HART_W-1:0] hart, logic [1:0] status);
		owts_pkg::res_t r;
		r.next_slot = 4'(slot);
		r.switched  = (slot != caller);
		r.next_hart = hart;
		r.status    = status;
		return r;
	endfunction

	// Mark the caller, free the other zombies and start the runnable slot that
	// has waited longest; strict compare keeps ties on the lowest slot.
	function automatic owts_pkg::res_t pick_oldest(int caller,
			logic [owts_pkg::STATE_W-1:0] mark);
		int pick;
		pick = -1;
		slot_st[caller] = mark;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_st[i] == owts_pkg::ST_ZOMBIE && i != caller) begin
				slot_st[i] = owts_pkg::ST_FREE;
			end else if (slot_st[i] == owts_pkg::ST_RUNNABLE &&
					(pick < 0 || slot_wait[i] < slot_wait[pick])) begin
				pick = i;
			end
		end
		if (pick < 0)
			return make_result(caller, caller, slot_hrt[caller], owts_pkg::STATUS_NORUN);
		slot_st[pick] = owts_pkg::ST_RUNNING;
		if (pick != caller)
			slot_hrt[pick] = slot_hrt[caller];
		return make_result(pick, caller, slot_hrt[pick], owts_pkg::STATUS_OK);
	endfunction

	function automatic owts_pkg::res_t predict_schedule(owts_pkg::ev_t e);
		int c;
		int t;
		int free_slot;
		owts_pkg::res_t r;
		c = int'(e.caller_slot);
		t = int'(e.target_slot);
		case (e.kind)
			owts_pkg::KIND_INIT: begin
				// wait stamp deliberately left alone
				slot_st[c]  = owts_pkg::ST_RUNNING;
				slot_hrt[c] = e.hart_id;
				r = make_result(c, c, e.hart_id, owts_pkg::STATUS_OK);
			end
			owts_pkg::KIND_YIELD: begin
				slot_wait[c] = e.now;
				r = pick_oldest(c, owts_pkg::ST_RUNNABLE);
			end
			owts_pkg::KIND_BLOCK: r = pick_oldest(c, owts_pkg::ST_BLOCKED);
			owts_pkg::KIND_EXIT:  r = pick_oldest(c, owts_pkg::ST_ZOMBIE);
			owts_pkg::KIND_RUN: begin
				free_slot = -1;
				for (int i = 0; i < NUM_SLOTS; i++)
					if (free_slot < 0 && i != c && slot_st[i] == owts_pkg::ST_FREE)
						free_slot = i;
				if (free_slot < 0) begin
					r = make_result(c, c, slot_hrt[c], owts_pkg::STATUS_NOFREE);
				end else begin
					slot_st[c]           = owts_pkg::ST_RUNNABLE;
					slot_wait[c]         = e.now;
					slot_st[free_slot]   = owts_pkg::ST_RUNNING;
					slot_wait[free_slot] = e.now;
					slot_hrt[free_slot]  = slot_hrt[c];
					r = make_result(free_slot, c, slot_hrt[free_slot], owts_pkg::STATUS_OK);
				end
			end
			owts_pkg::KIND_WAKE: begin
				if (slot_st[t] == owts_pkg::ST_BLOCKED) begin
					slot_st[t]   = owts_pkg::ST_RUNNABLE;
					slot_wait[t] = e.now;
				end
				r = make_result(c, c, slot_hrt[c], owts_pkg::STATUS_OK);
			end
			default: r = make_result(c, c, slot_hrt[c], owts_pkg::STATUS_OK);
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic owts_pkg::ev_t mk_event(logic [2:0] kind, int caller, int target,
			logic [owts_pkg::HART_W-1:0] hart, logic [31:0] stamp);
		owts_pkg::ev_t e;
		e.kind        = kind;
		e.caller_slot = 4'(caller);
		e.target_slot = 4'(target);
		e.hart_id     = hart;
		e.now         = stamp;
		return e;
	endfunction

	// random slot currently in the given state, -1 when there is none
	function automatic int slot_in_state(logic [owts_pkg::STATE_W-1:0] st);
		int hits [$];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_st[i] == st)
				hits.push_back(i);
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	// Mostly advancing stamps; some repeats to force wait-time ties and some
	// fully random values so every bit of the field toggles.
	function automatic logic [31:0] next_stamp();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return $urandom();
		if (roll == 1)
			return clock_now;
		clock_now = clock_now + $urandom_range(1, 60);
		return clock_now;
	endfunction

	// Well-formed event issued by a running task most of the time; a small
	// share is raw noise with any caller and any kind.
	function automatic owts_pkg::ev_t random_event();
		int roll;
		int caller;
		int target;
		logic [2:0] kind;
		roll   = $urandom_range(0, 99);
		caller = slot_in_state(owts_pkg::ST_RUNNING);
		target = $urandom_range(0, NUM_SLOTS - 1);
		if (roll >= 97)
			return mk_event(3'($urandom_range(0, 7)), $urandom_range(0, NUM_SLOTS - 1),
				target, 3'($urandom()), $urandom());
		if (caller < 0 || roll >= 90) begin
			// nothing running (or a plain restart): bring a slot up
			kind   = owts_pkg::KIND_INIT;
			caller = $urandom_range(0, NUM_SLOTS - 1);
		end else if (roll < 28) begin
			kind = owts_pkg::KIND_YIELD;
		end else if (roll < 42) begin
			kind = owts_pkg::KIND_BLOCK;
		end else if (roll < 52) begin
			kind = owts_pkg::KIND_EXIT;
		end else if (roll < 72) begin
			kind = owts_pkg::KIND_RUN;
		end else if (roll < 87) begin
			kind = owts_pkg::KIND_WAKE;
			if (slot_in_state(owts_pkg::ST_BLOCKED) >= 0 && $urandom_range(0, 3) != 0)
				target = slot_in_state(owts_pkg::ST_BLOCKED);
		end else begin
			kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE6 : KIND_SPARE7;
		end
		return mk_event(kind, caller, target, 3'($urandom()), next_stamp());
	endfunction

	// One event transfer. Called from anywhere; drives at the falling edge,
	// leaves valid high on return so back-to-back transfers have no gap.
	task automatic send_event(input owts_pkg::ev_t e);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 6) == 0) begin
			ev_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		ev_if.valid <= 1'b1;
		ev_if.data  <= e;
		do @(posedge clk); while (!ev_if.ready);
		due_results.push_back(predict_schedule(e));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		ev_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Hand-picked walk through every kind and the corner cases.
	task automatic test_directed_events();
		// unused caller, nothing runnable
		send_event(mk_event(owts_pkg::KIND_BLOCK, 5, 0, 3'd0, 32'd0));
		send_event(mk_event(owts_pkg::KIND_INIT, 0, 15, 3'd7, 32'hFFFF_FFFF));
		send_event(mk_event(owts_pkg::KIND_INIT, 15, 0, 3'd0, 32'd0));
		// new slot on hart 7
		send_event(mk_event(owts_pkg::KIND_RUN, 0, 0, 3'd0, 32'd0));
		send_event(mk_event(owts_pkg::KIND_RUN, 15, 0, 3'd0, 32'd0));
		// tie at stamp 0 -> lowest
		send_event(mk_event(owts_pkg::KIND_YIELD, 1, 0, 3'd0, 32'hFFFF_FFFF));
		send_event(mk_event(owts_pkg::KIND_EXIT, 2, 0, 3'd0, 32'd100));
		// frees the zombie
		send_event(mk_event(owts_pkg::KIND_BLOCK, 0, 0, 3'd0, 32'd101));
		// blocked target, then a free one and a running one with no effect
		send_event(mk_event(owts_pkg::KIND_WAKE, 1, 0, 3'd5, 32'd200));
		send_event(mk_event(owts_pkg::KIND_WAKE, 1, 3, 3'd2, 32'd201));
		send_event(mk_event(owts_pkg::KIND_WAKE, 1, 15, 3'd2, 32'd202));
		send_event(mk_event(KIND_SPARE6, 1, 7, 3'd7, 32'h5555_5555));
		send_event(mk_event(KIND_SPARE7, 14, 8, 3'd1, 32'hAAAA_AAAA));
		// unused caller yields
		send_event(mk_event(owts_pkg::KIND_YIELD, 9, 0, 3'd0, 32'd50));
		send_event(mk_event(owts_pkg::KIND_EXIT, 15, 0, 3'd0, 32'd300));
		send_event(mk_event(owts_pkg::KIND_EXIT, 0, 0, 3'd0, 32'd301));
		send_event(mk_event(owts_pkg::KIND_EXIT, 1, 0, 3'd0, 32'd302));
		send_event(mk_event(owts_pkg::KIND_EXIT, 9, 0, 3'd0, 32'd303));
		clock_now = 32'd400;
	endtask

	// Fill every slot from one caller until run reports no free slot.
	task automatic test_full_table();
		send_event(mk_event(owts_pkg::KIND_INIT, 4, 0, 3'd3, 32'd0));
		for (int n = 0; n < NUM_SLOTS; n++)
			send_event(mk_event(owts_pkg::KIND_RUN, 4, 0, 3'd0, next_stamp()));
		send_event(mk_event(owts_pkg::KIND_RUN, 9, 0, 3'd0, next_stamp()));
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_event(random_event());
	endtask

	// Receiver stalls for a long stretch while events keep coming, so the
	// block fills up and has to drop ev.ready.
	task automatic test_backpressure();
		rx_hold_req = HOLD_CYC;
		repeat (12) send_event(random_event());
	endtask

	// Sender goes quiet until every outstanding result has come back.
	task automatic test_drain_pause();
		stop_sending();
		wait (due_results.size() == 0);
		test_random_mix(20);
	endtask

	task automatic test_no_idle_tail();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_mix(TAIL_EVENTS);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("oldest_waiting_task_scheduler: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: ready with random stall bursts, plus the long hold-off
	// counted here. Ready changes only at the falling edge, once per step.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (!arst_n) begin
				res_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				res_if.ready <= 1'b0;
				hold_left = $urandom_range(0, 10);   // start of a random stall burst
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input owts_pkg::res_t want,
			input owts_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected slot %0d sw %0b hart %0d st %0d",
				$realtime, what, want.next_slot, want.switched, want.next_hart, want.status);
			$display("%0t: %s: actual   slot %0d sw %0b hart %0d st %0d",
				$realtime, what, got.next_slot, got.switched, got.next_hart, got.status);
		end
	endtask

	// Score every result transfer against the oldest prediction.
	always @(posedge clk) begin
		owts_pkg::res_t want;
		owts_pkg::res_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", '0, got);
			end else begin
				want = due_results.pop_front();
				if (got.next_slot !== want.next_slot || got.switched !== want.switched ||
						got.next_hart !== want.next_hart || got.status !== want.status)
					report_mismatch("result differs", want, got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		ev_if.valid = 1'b0;
		ev_if.data  = '0;
		mismatches  = 0;
		rx_hold_req = 0;
		tx_idle_en  = 1'b1;
		rx_idle_en  = 1'b1;
		clock_now   = 32'd0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_st[i]   = owts_pkg::ST_FREE;
			slot_wait[i] = '0;
			slot_hrt[i]  = '0;
		end
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_full_table();
		test_random_mix(150);
		test_backpressure();
		test_random_mix(120);
		test_drain_pause();
		test_random_mix(RAND_EVENTS - 150 - 12 - 120 - 20 - TAIL_EVENTS);
		test_no_idle_tail();

		stop_sending();
		wait (due_results.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("oldest_waiting_task_scheduler: match");
		else
			$display("oldest_waiting_task_scheduler: mismatch");
		$finish;
	end

endmodule
